### sv/tsst_pkg.sv
// Shared types and constants of the task schedule span tracker.
package tsst_pkg;

   // Table geometry: direct-mapped, one slot per low task id bits
   localparam int TABLE_ADDR_W  = 10;
   localparam int TABLE_ENTRIES = 1 << TABLE_ADDR_W;

   // Event codes
   localparam logic [1:0] ACT_SWITCH_OUT = 2'd0;
   localparam logic [1:0] ACT_SWITCH_IN  = 2'd1;
   localparam logic [1:0] ACT_WAKEUP     = 2'd2;
   localparam logic [1:0] ACT_EXIT       = 2'd3;

   // Phase codes held in a slot
   localparam logic [1:0] PHASE_RUNNING  = 2'd1;
   localparam logic [1:0] PHASE_BLOCKED  = 2'd2;
   localparam logic [1:0] PHASE_RUNNABLE = 2'd3;

   // Runnable reason codes
   localparam logic [1:0] REASON_NONE    = 2'd0;
   localparam logic [1:0] REASON_PREEMPT = 2'd1;
   localparam logic [1:0] REASON_STILL   = 2'd2;
   localparam logic [1:0] REASON_WAKEUP  = 2'd3;

   // Span kinds
   localparam logic [1:0] KIND_RUN   = 2'd0;
   localparam logic [1:0] KIND_BLOCK = 2'd1;
   localparam logic [1:0] KIND_WAIT  = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [21:0] task_id;
      logic [21:0] group_id;
      logic        group_tracked;
      logic [62:0] timestamp;
      logic [7:0]  cpu_index;
      logic        preempted;
      logic [31:0] prior_state_bits;
      logic [62:0] blocking_frame;
   } tsst_req_type;

   typedef struct packed {
      logic [21:0] span_group;
      logic [21:0] span_task;
      logic [62:0] span_start;
      logic [62:0] span_end;
      logic [7:0]  span_cpu;
      logic [1:0]  span_kind;
      logic [62:0] span_frame;
      logic [1:0]  span_reason;
      logic [31:0] span_state_bits;
   } tsst_rsp_type;

   typedef struct packed {
      logic        valid;
      logic [21:0] task_tag;
      logic [62:0] since;
      logic [62:0] frame;
      logic [7:0]  cpu;
      logic [1:0]  phase;
      logic [1:0]  reason;
      logic [31:0] state_bits;
      logic        exiting;
   } tsst_slot_type;

   localparam int SLOT_W = $bits(tsst_slot_type);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                    accept;
      logic                    commit;
      logic                    clear;
      logic [TABLE_ADDR_W-1:0] clear_addr;
   } tsst_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;
   } tsst_status_type;

endpackage

### sv/task_schedule_span_tracker.sv
// Top level of the task schedule span tracker.
//
// Usage:
//  - req_* carries one scheduler event per transaction (valid/ready); rsp_*
//    returns at most one span per event (valid/ready); csr_* writes the
//    one-bit group filter enable, always ready.
//  - In ST_IDLE, the cycle of acceptance issues the read of the task's slot
//    from the slot table (one write port, one read port, registered read);
//    ST_EXEC then updates the slot and loads the span into the output
//    register, waiting while the output register is not free. req_ready is
//    low in ST_EXEC, so no new event is taken before the last one is done.
//  - A span is valid on rsp_valid once the output register has loaded it in
//    the update step.
//  - After reset the table is swept clear, one slot per cycle, over all
//    TABLE_ENTRIES (1024) slots; req_ready stays low meanwhile. The filter
//    enable resets to 0.
//  - When the receiver stalls, a pending span is held in the output register;
//    one more event may be accepted and read, and its update waits until the
//    output register is free.
module task_schedule_span_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tsst_pkg::tsst_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tsst_pkg::tsst_rsp_type rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);

   tsst_pkg::tsst_cmd_type    cmd;
   tsst_pkg::tsst_status_type status;

   // Sequencer
   tsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table and span logic
   tsst_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

endmodule

### sv/tsst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tsst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/tsst_ctrl.sv
// Controller: table clearing sweep, then a read / update sequence per transaction.
module tsst_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tsst_pkg::tsst_status_type status,
   output tsst_pkg::tsst_cmd_type    cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]                        state_ff;
   logic [1:0]                        state_in;
   logic [tsst_pkg::TABLE_ADDR_W-1:0] clear_cnt_ff;
   logic [tsst_pkg::TABLE_ADDR_W-1:0] clear_cnt_in;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      clear_cnt_in   = clear_cnt_ff;
      req_ready      = 1'b0;
      cmd.accept     = 1'b0;
      cmd.commit     = 1'b0;
      cmd.clear      = 1'b0;
      cmd.clear_addr = clear_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear    = 1'b1;
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (&clear_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Hold until the output register can take a span
            cmd.commit = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

endmodule

### sv/tsst_dpath.sv
// Datapath: slot table, transaction register, span decision and output register.
module tsst_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  tsst_pkg::tsst_cmd_type    cmd,
   output tsst_pkg::tsst_status_type status,
   input  tsst_pkg::tsst_req_type    req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tsst_pkg::tsst_rsp_type    rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_data
);

   tsst_pkg::tsst_req_type            item_ff;
   tsst_pkg::tsst_rsp_type            rsp_payload_ff;
   tsst_pkg::tsst_rsp_type            rsp_payload_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic                              filter_enabled_ff;

   logic [tsst_pkg::SLOT_W-1:0]       ram_rdata;
   logic [tsst_pkg::SLOT_W-1:0]       ram_wdata;
   logic [tsst_pkg::TABLE_ADDR_W-1:0] ram_waddr;
   logic                              ram_we;

   tsst_pkg::tsst_slot_type           slot_rd;
   tsst_pkg::tsst_slot_type           slot_wr;
   logic                              ignore;
   logic                              hit;
   logic                              wr_need;
   logic                              span_try;
   logic                              span_ok;
   logic                              emit;
   logic [7:0]                        span_cpu;
   logic [1:0]                        span_kind;
   logic [62:0]                       span_frame;
   logic [1:0]                        span_reason;
   logic [31:0]                       span_sbits;

   // Build a complete, valid slot entry
   function automatic tsst_pkg::tsst_slot_type make_slot(
      input logic [21:0] tid,
      input logic [62:0] since,
      input logic [62:0] frame,
      input logic [7:0]  cpu,
      input logic [1:0]  phase,
      input logic [1:0]  reason,
      input logic [31:0] sbits,
      input logic        exiting
   );
      tsst_pkg::tsst_slot_type s;
      s.valid      = 1'b1;
      s.task_tag   = tid;
      s.since      = since;
      s.frame      = frame;
      s.cpu        = cpu;
      s.phase      = phase;
      s.reason     = reason;
      s.state_bits = sbits;
      s.exiting    = exiting;
      return s;
   endfunction

   // Slot table
   tsst_ram #(
      .WIDTH (tsst_pkg::SLOT_W),
      .DEPTH (tsst_pkg::TABLE_ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (req_payload.task_id[tsst_pkg::TABLE_ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_payload;
      end
   end

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enabled_ff <= 1'b0;
      end else if (csr_valid) begin
         filter_enabled_ff <= csr_data;
      end
   end

   assign slot_rd = tsst_pkg::tsst_slot_type'(ram_rdata);
   assign ignore  = (item_ff.task_id == '0) ||
                    (filter_enabled_ff &&
                     ((item_ff.group_id == '0) || !item_ff.group_tracked));
   assign hit     = slot_rd.valid && (slot_rd.task_tag == item_ff.task_id);

   // Decide the span and the updated slot per event
   always_comb begin
      span_try    = 1'b0;
      span_cpu    = slot_rd.cpu;
      span_kind   = tsst_pkg::KIND_RUN;
      span_frame  = '0;
      span_reason = tsst_pkg::REASON_NONE;
      span_sbits  = '0;
      slot_wr     = slot_rd;
      wr_need     = 1'b1;
      unique case (item_ff.action)
         tsst_pkg::ACT_SWITCH_OUT: begin
            span_try = hit && (slot_rd.phase == tsst_pkg::PHASE_RUNNING);
            if (hit && slot_rd.exiting) begin
               // Drop the exiting task
               slot_wr.valid = 1'b0;
            end else if (item_ff.preempted || (item_ff.prior_state_bits == '0)) begin
               slot_wr = make_slot(item_ff.task_id, item_ff.timestamp, '0,
                                   item_ff.cpu_index, tsst_pkg::PHASE_RUNNABLE,
                                   item_ff.preempted ? tsst_pkg::REASON_PREEMPT
                                                     : tsst_pkg::REASON_STILL,
                                   '0, 1'b0);
            end else begin
               slot_wr = make_slot(item_ff.task_id, item_ff.timestamp,
                                   item_ff.blocking_frame, item_ff.cpu_index,
                                   tsst_pkg::PHASE_BLOCKED, tsst_pkg::REASON_NONE,
                                   item_ff.prior_state_bits, 1'b0);
            end
         end
         tsst_pkg::ACT_SWITCH_IN: begin
            if (hit && (slot_rd.phase == tsst_pkg::PHASE_RUNNABLE)) begin
               span_try    = 1'b1;
               span_cpu    = item_ff.cpu_index;
               span_kind   = tsst_pkg::KIND_WAIT;
               span_reason = slot_rd.reason;
            end else if (hit && (slot_rd.phase == tsst_pkg::PHASE_BLOCKED)) begin
               span_try   = 1'b1;
               span_kind  = tsst_pkg::KIND_BLOCK;
               span_frame = slot_rd.frame;
               span_sbits = slot_rd.state_bits;
            end
            slot_wr = make_slot(item_ff.task_id, item_ff.timestamp, '0,
                                item_ff.cpu_index, tsst_pkg::PHASE_RUNNING,
                                tsst_pkg::REASON_NONE, '0, 1'b0);
         end
         tsst_pkg::ACT_WAKEUP: begin
            if (hit && (slot_rd.phase != tsst_pkg::PHASE_BLOCKED)) begin
               // Not blocked: leave the slot alone
               wr_need = 1'b0;
            end else if (hit) begin
               span_try           = 1'b1;
               span_kind          = tsst_pkg::KIND_BLOCK;
               span_frame         = slot_rd.frame;
               span_sbits         = slot_rd.state_bits;
               slot_wr.since      = item_ff.timestamp;
               slot_wr.frame      = '0;
               slot_wr.phase      = tsst_pkg::PHASE_RUNNABLE;
               slot_wr.reason     = tsst_pkg::REASON_WAKEUP;
               slot_wr.state_bits = '0;
            end else begin
               slot_wr = make_slot(item_ff.task_id, item_ff.timestamp, '0,
                                   item_ff.cpu_index, tsst_pkg::PHASE_RUNNABLE,
                                   tsst_pkg::REASON_WAKEUP, '0, 1'b0);
            end
         end
         tsst_pkg::ACT_EXIT: begin
            if (hit) begin
               slot_wr.exiting = 1'b1;
            end else begin
               slot_wr = make_slot(item_ff.task_id, item_ff.timestamp, '0,
                                   item_ff.cpu_index, tsst_pkg::PHASE_RUNNING,
                                   tsst_pkg::REASON_NONE, '0, 1'b1);
            end
         end
         default: begin
            wr_need = 1'b0;
         end
      endcase
      if (ignore) begin
         span_try = 1'b0;
         wr_need  = 1'b0;
      end
   end

   // Suppress spans with a zero start or a start not before the end
   assign span_ok = (slot_rd.since != '0) && (slot_rd.since < item_ff.timestamp);
   assign emit    = cmd.commit && span_try && span_ok;

   // Table write: clearing sweep or update of the current transaction
   assign ram_we    = cmd.clear || (cmd.commit && wr_need);
   assign ram_waddr = cmd.clear ? cmd.clear_addr
                                : item_ff.task_id[tsst_pkg::TABLE_ADDR_W-1:0];
   assign ram_wdata = cmd.clear ? '0 : slot_wr;

   // Output register
   always_comb begin
      rsp_payload_in.span_group      = item_ff.group_id;
      rsp_payload_in.span_task       = item_ff.task_id;
      rsp_payload_in.span_start      = slot_rd.since;
      rsp_payload_in.span_end        = item_ff.timestamp;
      rsp_payload_in.span_cpu        = span_cpu;
      rsp_payload_in.span_kind       = span_kind;
      rsp_payload_in.span_frame      = span_frame;
      rsp_payload_in.span_reason     = span_reason;
      rsp_payload_in.span_state_bits = span_sbits;
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_payload_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Table is never written in the cycle a read is issued
   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !ram_we)
      else $error("slot table written during read issue");

   // A span appears only from an update step
   a_span_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("span shown without an update step");

   // Two transactions are never accepted back to back
   a_accept_spacing: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !cmd.accept)
      else $error("back-to-back acceptance");

   // Nothing is emitted while the table is being cleared
   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (!rsp_valid_ff && !cmd.accept))
      else $error("activity during clearing sweep");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the task schedule span tracker.
`timescale 1ns / 100ps

module tb_top;

   localparam int QUIET_LIMIT = 4000;
   localparam int POOL        = 24;

   // Scheduler walk of one task in the random traffic
   typedef enum {
      WALK_FRESH,
      WALK_RUNNING,
      WALK_EXITING,
      WALK_READY,
      WALK_SLEEPING
   } task_walk_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   tsst_pkg::tsst_req_type req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   tsst_pkg::tsst_rsp_type rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic                   csr_data    = 1'b0;

   // Handshake flags sampled at the rising edge, used at the falling edge
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic csr_taken = 1'b0;

   // Span tracking state mirrored by the testbench
   logic                    filter_on;
   tsst_pkg::tsst_slot_type slot_table [tsst_pkg::TABLE_ENTRIES];
   tsst_pkg::tsst_rsp_type  pending_spans[$];

   tsst_pkg::tsst_req_type  event_queue[$];
   int            events_sent  = 0;
   int            events_taken = 0;
   int            error_count  = 0;
   int            quiet_cycles = 0;

   int            send_pause = 0;
   int            recv_pause = 0;
   int            stall;
   bit            send_calm  = 1'b0;
   bit            recv_calm  = 1'b0;

   // Random traffic: a pool of tasks walked through plausible sequences
   logic [21:0]   pool_tid  [POOL];
   logic [21:0]   pool_grp  [POOL];
   logic          pool_trk  [POOL];
   task_walk_type pool_walk [POOL];
   logic [62:0]   walk_clock;

   task_schedule_span_tracker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Span prediction
   // ---------------------------------------------------------------

   // Queue a span unless its start is zero or not before its end
   function automatic void queue_span(tsst_pkg::tsst_req_type ev, logic [62:0] since,
                                      logic [7:0] cpu, logic [1:0] kind,
                                      logic [62:0] frame, logic [1:0] reason,
                                      logic [31:0] bits);
      tsst_pkg::tsst_rsp_type span;
      if (since == '0 || since >= ev.timestamp) return;
      span.span_group      = ev.group_id;
      span.span_task       = ev.task_id;
      span.span_start      = since;
      span.span_end        = ev.timestamp;
      span.span_cpu        = cpu;
      span.span_kind       = kind;
      span.span_frame      = frame;
      span.span_reason     = reason;
      span.span_state_bits = bits;
      pending_spans.push_back(span);
   endfunction

   function automatic tsst_pkg::tsst_slot_type make_slot(tsst_pkg::tsst_req_type ev,
                                                         logic [62:0] frame,
                                                         logic [1:0] phase,
                                                         logic [1:0] reason,
                                                         logic [31:0] bits,
                                                         logic exiting);
      tsst_pkg::tsst_slot_type s;
      s.valid      = 1'b1;
      s.task_tag   = ev.task_id;
      s.since      = ev.timestamp;
      s.frame      = frame;
      s.cpu        = ev.cpu_index;
      s.phase      = phase;
      s.reason     = reason;
      s.state_bits = bits;
      s.exiting    = exiting;
      return s;
   endfunction

   // Advance the task table by one scheduler event
   function automatic void track_event(tsst_pkg::tsst_req_type ev);
      tsst_pkg::tsst_slot_type           cur;
      logic [tsst_pkg::TABLE_ADDR_W-1:0] idx;
      logic                              hit;
      if (ev.task_id == '0) return;
      if (filter_on && (ev.group_id == '0 || !ev.group_tracked)) return;
      idx = ev.task_id[tsst_pkg::TABLE_ADDR_W-1:0];
      cur = slot_table[idx];
      hit = cur.valid && cur.task_tag == ev.task_id;
      case (ev.action)
         tsst_pkg::ACT_SWITCH_OUT: begin
            if (hit && cur.phase == tsst_pkg::PHASE_RUNNING)
               queue_span(ev, cur.since, cur.cpu, tsst_pkg::KIND_RUN, '0,
                  tsst_pkg::REASON_NONE, '0);
            if (hit && cur.exiting) begin
               slot_table[idx].valid = 1'b0;
            end else if (ev.preempted || ev.prior_state_bits == '0) begin
               slot_table[idx] = make_slot(ev, '0, tsst_pkg::PHASE_RUNNABLE,
                  ev.preempted ? tsst_pkg::REASON_PREEMPT : tsst_pkg::REASON_STILL,
                  '0, 1'b0);
            end else begin
               slot_table[idx] = make_slot(ev, ev.blocking_frame,
                  tsst_pkg::PHASE_BLOCKED, tsst_pkg::REASON_NONE,
                  ev.prior_state_bits, 1'b0);
            end
         end
         tsst_pkg::ACT_SWITCH_IN: begin
            if (hit && cur.phase == tsst_pkg::PHASE_RUNNABLE)
               queue_span(ev, cur.since, ev.cpu_index, tsst_pkg::KIND_WAIT, '0,
                  cur.reason, '0);
            else if (hit && cur.phase == tsst_pkg::PHASE_BLOCKED)
               queue_span(ev, cur.since, cur.cpu, tsst_pkg::KIND_BLOCK, cur.frame,
                  tsst_pkg::REASON_NONE, cur.state_bits);
            slot_table[idx] = make_slot(ev, '0, tsst_pkg::PHASE_RUNNING,
               tsst_pkg::REASON_NONE, '0, 1'b0);
         end
         tsst_pkg::ACT_WAKEUP: begin
            if (!hit) begin
               slot_table[idx] = make_slot(ev, '0, tsst_pkg::PHASE_RUNNABLE,
                  tsst_pkg::REASON_WAKEUP, '0, 1'b0);
            end else if (cur.phase == tsst_pkg::PHASE_BLOCKED) begin
               queue_span(ev, cur.since, cur.cpu, tsst_pkg::KIND_BLOCK, cur.frame,
                  tsst_pkg::REASON_NONE, cur.state_bits);
               slot_table[idx].since      = ev.timestamp;
               slot_table[idx].frame      = '0;
               slot_table[idx].phase      = tsst_pkg::PHASE_RUNNABLE;
               slot_table[idx].reason     = tsst_pkg::REASON_WAKEUP;
               slot_table[idx].state_bits = '0;
            end
         end
         tsst_pkg::ACT_EXIT: begin
            if (hit)
               slot_table[idx].exiting = 1'b1;
            else
               slot_table[idx] = make_slot(ev, '0, tsst_pkg::PHASE_RUNNING,
                  tsst_pkg::REASON_NONE, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_span(tsst_pkg::tsst_rsp_type got);
      tsst_pkg::tsst_rsp_type want;
      if (pending_spans.size() == 0) begin
         $error("span with none pending: task %0h start %0h end %0h",
                got.span_task, got.span_start, got.span_end);
         error_count++;
         return;
      end
      want = pending_spans.pop_front();
      check_field("span_group", want.span_group, got.span_group);
      check_field("span_task", want.span_task, got.span_task);
      check_field("span_start", want.span_start, got.span_start);
      check_field("span_end", want.span_end, got.span_end);
      check_field("span_cpu", want.span_cpu, got.span_cpu);
      check_field("span_kind", want.span_kind, got.span_kind);
      check_field("span_frame", want.span_frame, got.span_frame);
      check_field("span_reason", want.span_reason, got.span_reason);
      check_field("span_state_bits", want.span_state_bits, got.span_state_bits);
   endfunction

   // ---------------------------------------------------------------
   // Monitor: sample handshakes, predict, check, watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         rsp_taken    <= 1'b0;
         csr_taken    <= 1'b0;
         filter_on    = 1'b0;
         quiet_cycles = 0;
         foreach (slot_table[i]) slot_table[i] = '0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         csr_taken <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) filter_on = csr_data;
         if (rsp_valid && rsp_ready) check_span(rsp_payload);
         if (req_valid && req_ready) begin
            track_event(req_payload);
            events_taken++;
         end
         // Count cycles with no transaction on any channel
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Driver and receiver, both at the falling edge
   // ---------------------------------------------------------------
   function automatic int draw_pause(bit calm);
      return calm ? 0 : int'($urandom_range(0, 8));
   endfunction

   // Hold each event until accepted, then pause before the next one
   always @(negedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         send_pause <= 0;
      end else if (!req_valid || req_taken) begin
         if (send_pause > 0) begin
            req_valid  <= 1'b0;
            send_pause <= send_pause - 1;
         end else if (event_queue.size() > 0) begin
            req_payload <= event_queue.pop_front();
            req_valid   <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            send_pause <= draw_pause(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel for a drawn number of cycles after each span
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_pause <= 0;
      end else if (rsp_taken) begin
         if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
         stall = draw_pause(recv_calm);
         rsp_ready  <= (stall == 0);
         recv_pause <= (stall == 0) ? 0 : stall - 1;
      end else if (recv_pause > 0) begin
         rsp_ready  <= 1'b0;
         recv_pause <= recv_pause - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic queue_event(tsst_pkg::tsst_req_type ev);
      event_queue.push_back(ev);
      events_sent++;
   endtask

   task automatic queue_direct(logic [1:0] act, logic [21:0] tid, logic [62:0] ts,
                               logic [7:0] cpu = 8'd1, logic pre = 1'b0,
                               logic [31:0] pstate = '0, logic [62:0] frame = '0,
                               logic [21:0] grp = 22'd7, logic trk = 1'b1);
      tsst_pkg::tsst_req_type ev;
      ev.action           = act;
      ev.task_id          = tid;
      ev.group_id         = grp;
      ev.group_tracked    = trk;
      ev.timestamp        = ts;
      ev.cpu_index        = cpu;
      ev.preempted        = pre;
      ev.prior_state_bits = pstate;
      ev.blocking_frame   = frame;
      queue_event(ev);
   endtask

   task automatic write_filter(logic value);
      @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   // Wait until every event is taken and every span has come back
   task automatic wait_idle();
      while (events_taken != events_sent || pending_spans.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Build a task pool with small ids, random ids and slot collisions
   task automatic seed_pool(logic [62:0] start);
      walk_clock = start;
      for (int k = 0; k < POOL; k++) begin
         if (k == 0)
            pool_tid[k] = 22'h3FFFFF;
         else if (k % 4 == 3)
            pool_tid[k] = pool_tid[k-1] ^
                          (22'($urandom_range(1, 4095)) << tsst_pkg::TABLE_ADDR_W);
         else if (k < 6)
            pool_tid[k] = 22'($urandom_range(1, 64));
         else
            pool_tid[k] = 22'($urandom_range(1, 22'h3FFFFF));
         if (pool_tid[k] == '0) pool_tid[k] = 22'd1;
         pool_grp[k]  = ($urandom_range(0, 9) == 0) ? '0 : 22'($urandom);
         pool_trk[k]  = ($urandom_range(0, 5) != 0);
         pool_walk[k] = WALK_FRESH;
      end
   endtask

   // Step one pool task through a well-formed scheduler sequence
   task automatic walk_step(int k);
      tsst_pkg::tsst_req_type ev;
      walk_clock          = walk_clock + 63'($urandom_range(0, 400));
      ev.task_id          = pool_tid[k];
      ev.group_id         = pool_grp[k];
      ev.group_tracked    = pool_trk[k];
      ev.timestamp        = walk_clock;
      ev.cpu_index        = 8'($urandom);
      ev.preempted        = ($urandom_range(0, 2) == 0);
      ev.prior_state_bits = ($urandom_range(0, 2) == 0) ? '0 : 32'($urandom);
      ev.blocking_frame   = 63'({$urandom, $urandom});
      case (pool_walk[k])
         WALK_RUNNING: begin
            if ($urandom_range(0, 9) == 0) begin
               ev.action    = tsst_pkg::ACT_EXIT;
               pool_walk[k] = WALK_EXITING;
            end else begin
               ev.action    = tsst_pkg::ACT_SWITCH_OUT;
               pool_walk[k] = (ev.preempted || ev.prior_state_bits == '0) ?
                              WALK_READY : WALK_SLEEPING;
            end
         end
         WALK_EXITING: begin
            ev.action    = tsst_pkg::ACT_SWITCH_OUT;
            pool_walk[k] = WALK_FRESH;
         end
         WALK_READY: begin
            ev.action    = tsst_pkg::ACT_SWITCH_IN;
            pool_walk[k] = WALK_RUNNING;
         end
         WALK_SLEEPING: begin
            if ($urandom_range(0, 2) != 0) begin
               ev.action    = tsst_pkg::ACT_WAKEUP;
               pool_walk[k] = WALK_READY;
            end else begin
               ev.action    = tsst_pkg::ACT_SWITCH_IN;
               pool_walk[k] = WALK_RUNNING;
            end
         end
         default: begin
            case ($urandom_range(0, 5))
               0: begin
                  ev.action    = tsst_pkg::ACT_WAKEUP;
                  pool_walk[k] = WALK_READY;
               end
               1: begin
                  ev.action    = tsst_pkg::ACT_EXIT;
                  pool_walk[k] = WALK_EXITING;
               end
               default: begin
                  ev.action    = tsst_pkg::ACT_SWITCH_IN;
                  pool_walk[k] = WALK_RUNNING;
               end
            endcase
         end
      endcase
      queue_event(ev);
   endtask

   // Broken traffic: any action, any id, any time
   task automatic queue_noise();
      tsst_pkg::tsst_req_type ev;
      ev.action = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
         0:       ev.task_id = '0;
         1:       ev.task_id = pool_tid[$urandom_range(0, POOL - 1)];
         default: ev.task_id = 22'($urandom);
      endcase
      ev.group_id         = ($urandom_range(0, 3) == 0) ? '0 : 22'($urandom);
      ev.group_tracked    = 1'($urandom_range(0, 1));
      ev.timestamp        = ($urandom_range(0, 3) == 0) ? '0 : 63'({$urandom, $urandom});
      ev.cpu_index        = 8'($urandom);
      ev.preempted        = 1'($urandom_range(0, 1));
      ev.prior_state_bits = 32'($urandom);
      ev.blocking_frame   = 63'({$urandom, $urandom});
      queue_event(ev);
   endtask

   task automatic queue_random(int count, logic [62:0] start);
      seed_pool(start);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 11) == 0)
            queue_noise();
         else
            walk_step($urandom_range(0, POOL - 1));
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: every transition of one task, then the corner cases
      write_filter(1'b0);
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd5, 63'd100, 8'd0);
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'd5, 63'd200, 8'd0, 1'b1);
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd5, 63'd300, 8'd255);
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'd5, 63'd400, 8'd255, 1'b0, 32'hFFFFFFFF,
                   63'h7FFFFFFFFFFFFFFF);
      queue_direct(tsst_pkg::ACT_WAKEUP,     22'd5, 63'd500, 8'd9);
      // wakeup of a task that is not blocked
      queue_direct(tsst_pkg::ACT_WAKEUP,     22'd5, 63'd550, 8'd9);
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd5, 63'd600, 8'd4);
      // start equal to end: no span
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'd5, 63'd600, 8'd4);
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd5, 63'd700, 8'd4);
      // exit, then the final switch out drops the task
      queue_direct(tsst_pkg::ACT_EXIT,       22'd5, 63'd750);
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'd5, 63'd800);
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd5, 63'd900);
      // slot conflict: same slot, different tag
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd5 + 22'(tsst_pkg::TABLE_ENTRIES), 63'd950);
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'd5, 63'd1000, 8'd2, 1'b1);
      // zero task id is ignored
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'd0, 63'd1);
      // field extremes
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'h3FFFFF, 63'h7FFFFFFFFFFFFFFE, 8'd255, 1'b0,
                   '0, '0, 22'h3FFFFF, 1'b1);
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'h3FFFFF, 63'h7FFFFFFFFFFFFFFF, 8'd128, 1'b0,
                   32'd1, 63'h7FFFFFFFFFFFFFFF, 22'h3FFFFF, 1'b1);
      // start after end: no span
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'h3FFFFF, 63'd0, 8'd0, 1'b0, '0, '0,
                   22'h3FFFFF, 1'b0);
      // zero start: no span
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd7, 63'd0);
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'd7, 63'd50, 8'd1, 1'b0, 32'h80000000,
                   63'd1234);
      // exit of an unknown task
      queue_direct(tsst_pkg::ACT_EXIT,       22'd9, 63'd10, 8'd6);
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'd9, 63'd20, 8'd6);
      // wakeup of an unknown task
      queue_direct(tsst_pkg::ACT_WAKEUP,     22'd11, 63'd30, 8'd8);
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd11, 63'd40, 8'd3);
      wait_idle();

      // Filter on: zero group and untracked group are dropped
      write_filter(1'b1);
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd20, 63'd100, 8'd1, 1'b0, '0, '0,
                   22'd0, 1'b1);
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd20, 63'd200, 8'd1, 1'b0, '0, '0,
                   22'd5, 1'b0);
      queue_direct(tsst_pkg::ACT_SWITCH_IN,  22'd20, 63'd300, 8'd1, 1'b0, '0, '0,
                   22'd5, 1'b1);
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'd20, 63'd400, 8'd1, 1'b1, '0, '0,
                   22'd5, 1'b1);
      queue_direct(tsst_pkg::ACT_SWITCH_OUT, 22'd20, 63'd500, 8'd1, 1'b0, '0, '0,
                   22'd0, 1'b0);
      queue_random(240, 63'd1);
      wait_idle();

      write_filter(1'b0);
      queue_random(240, 63'({$urandom, $urandom}));
      wait_idle();

      // Run the clock across its wrap point
      write_filter(1'b1);
      queue_random(200, 63'h7FFFFFFFFFFF8000);
      wait_idle();

      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

### sim.f
sv/tsst_pkg.sv
sv/tsst_ram.sv
sv/tsst_ctrl.sv
sv/tsst_dpath.sv
sv/task_schedule_span_tracker.sv
dv/tb_top.sv
